// ===== hdl/fpa_pkg.sv =====
// Package for the fixed-point ALU: word types, opcodes, constants.
`default_nettype none
package fpa_pkg;
  localparam int FracBits = 8;
  localparam int DataW = 32;
  localparam int NumW = DataW + FracBits;
  localparam int DivSteps = NumW;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } op_t;

  typedef struct packed {
    logic [3:0] op;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic compare_flag;
    logic divide_by_zero;
  } out_word_t;

  // Classified word passed from front to back
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic neg_q;
    logic [NumW-1:0] num_mag;
    logic [DataW-1:0] den_mag;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    out_word_t simple;
  } job_t;
endpackage
`default_nettype wire

// ===== hdl/fpa_front.sv =====
// Front end: decodes the opcode, computes simple results, prepares mul/div operands.
`default_nettype none
module fpa_front import fpa_pkg::*; (
  input  wire in_word_t in_w,
  output job_t job
);
  logic signed [31:0] a, b;
  logic gt, eq;
  logic [DataW-1:0] ua_mag, ub_mag;
  op_t op;

  always_comb begin
    op = op_t'(in_w.op);
    a = in_w.operand_a;
    b = in_w.operand_b;
    gt = a > b;
    eq = a == b;
    ua_mag = a[31] ? (~a + 32'd1) : a;
    ub_mag = b[31] ? (~b + 32'd1) : b;
    job = '0;
    job.mul_a = a;
    job.mul_b = b;
    job.num_mag = {ua_mag, {FracBits{1'b0}}};
    job.den_mag = ub_mag;
    job.neg_q = a[31] ^ b[31];
    unique case (op)
      OP_ADD: job.simple.result_value = a + b;
      OP_SUB: job.simple.result_value = a - b;
      OP_MUL: job.is_mul = 1'b1;
      OP_DIV: begin
        job.is_div = (b != 32'sd0);
        job.simple.divide_by_zero = (b == 32'sd0);
      end
      OP_GT: job.simple.compare_flag = gt;
      OP_LT: job.simple.compare_flag = !gt && !eq;
      OP_GE: job.simple.compare_flag = gt || eq;
      OP_LE: job.simple.compare_flag = !gt;
      OP_EQ: job.simple.compare_flag = eq;
      OP_NE: job.simple.compare_flag = !eq;
      OP_MIN: job.simple.result_value = gt ? b : a;
      OP_MAX: job.simple.result_value = (gt || eq) ? a : b;
      OP_INC: job.simple.result_value = a + 32'sd1;
      OP_DEC: job.simple.result_value = a - 32'sd1;
      OP_FROM_INT: job.simple.result_value = a <<< FracBits;
      OP_TO_INT: job.simple.result_value = a >>> FracBits;
      default: job.simple.result_value = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/fpa_queue.sv =====
// Two-entry queue between front and back end.
`default_nettype none
module fpa_queue import fpa_pkg::*; (
  input  wire clk,
  input  wire rst,
  input  wire push,
  input  wire job_t push_job,
  output logic full,
  input  wire pop,
  output logic empty,
  output job_t head
);
  job_t mem [2];
  logic wp, rp;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign empty = count == 2'd0;
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_job;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== hdl/fpa_back.sv =====
// Back end: pipelined multiply and radix-2 divide, one job entering per cycle while advance is high.
`default_nettype none
module fpa_back import fpa_pkg::*; (
  input  wire clk,
  input  wire rst,
  input  wire job_valid,
  input  wire job_t job,
  input  wire advance,
  output logic out_valid,
  output out_word_t out_w
);
  localparam int Stages = DivSteps + 2;

  // Per-stage registers
  logic vld [Stages];
  job_t jb [Stages];
  logic [NumW-1:0] quo [Stages];
  logic [DataW:0] rem [Stages];
  logic signed [63:0] prod;
  logic signed [63:0] prod_sh;
  logic [NumW-1:0] qn;
  logic [DataW-1:0] q32;

  assign out_valid = vld[Stages-1];

  always_comb begin
    prod_sh = prod >>> FracBits;
    qn = quo[Stages-1];
    q32 = jb[Stages-1].neg_q ? (~qn[DataW-1:0] + 32'd1) : qn[DataW-1:0];
    out_w = jb[Stages-1].simple;
    if (jb[Stages-1].is_mul) out_w.result_value = prod_sh[31:0];
    if (jb[Stages-1].is_div) out_w.result_value = q32;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      jb[0] <= job;
      quo[0] <= job.num_mag;
      rem[0] <= '0;
      for (int s = 1; s <= DivSteps; s++) begin
        logic [DataW:0] trial;
        trial = {rem[s-1][DataW-1:0], quo[s-1][NumW-1]};
        jb[s] <= jb[s-1];
        if (trial >= {1'b0, jb[s-1].den_mag}) begin
          rem[s] <= trial - {1'b0, jb[s-1].den_mag};
          quo[s] <= {quo[s-1][NumW-2:0], 1'b1};
        end else begin
          rem[s] <= trial;
          quo[s] <= {quo[s-1][NumW-2:0], 1'b0};
        end
      end
      jb[Stages-1] <= jb[Stages-2];
      quo[Stages-1] <= quo[Stages-2];
      rem[Stages-1] <= rem[Stages-2];
      // Product lands in the same cycle as its job reaches the last stage
      prod <= jb[Stages-2].mul_a * jb[Stages-2].mul_b;
    end
    if (rst) begin
      for (int s = 0; s < Stages; s++) vld[s] <= 1'b0;
    end else if (advance) begin
      vld[0] <= job_valid;
      for (int s = 1; s < Stages; s++) vld[s] <= vld[s-1];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/fixed_point_alu.sv =====
// Top level of the fixed-point ALU: front decode, job queue, pipelined back end.
// An accepted word passes through the job queue and then the back-end pipeline stages to the output.
// Throughput: one word per cycle while the output is not stalled, set by the 40-step pipelined divider.
// The back pipeline advances when its output is empty or being taken.
// Reset (synchronous, rst high) empties the queue and the pipeline.
// No clearing pass; the block accepts a word in the first cycle after reset.
`default_nettype none
module fixed_point_alu import fpa_pkg::*; (
  input  wire clk,
  input  wire rst,
  input  wire in_valid,
  output logic in_stall,
  input  wire in_word_t in_data,
  output logic out_valid,
  input  wire out_stall,
  output out_word_t out_data
);
  job_t fjob, head;
  logic full, empty, advance, pop;

  fpa_front u_front (.in_w(in_data), .job(fjob));

  // Back end moves when its last stage is free or taken
  assign advance = !out_valid || !out_stall;
  assign pop = advance && !empty;
  assign in_stall = full;

  fpa_queue u_queue (
    .clk(clk), .rst(rst), .push(in_valid && !full), .push_job(fjob),
    .full(full), .pop(pop), .empty(empty), .head(head)
  );

  fpa_back u_back (
    .clk(clk), .rst(rst), .job_valid(!empty), .job(head), .advance(advance),
    .out_valid(out_valid), .out_w(out_data)
  );
endmodule
`default_nettype wire

// ===== hdl/fpa_checker.sv =====
// Port-level checker for the fixed-point ALU, bound to the top level.
`default_nettype none
module fpa_checker import fpa_pkg::*; (
  input wire clk,
  input wire rst,
  input wire in_valid,
  input wire in_stall,
  input wire out_valid,
  input wire out_stall,
  input wire out_word_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out held");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.compare_flag && out_data.divide_by_zero))
    else $error("flags clash");
  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divide_by_zero |-> out_data.result_value == 32'sd0)
    else $error("dz result");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("reset");
endmodule
bind fixed_point_alu fpa_checker u_chk (.*);
`default_nettype wire

// ===== tb/fixed_point_alu_test.sv =====
// Testbench for the fixed-point ALU: random and directed words checked against a scoreboard.
module fixed_point_alu_test;
  import fpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected-result store and checker
  class alu_scoreboard;
    out_word_t pending[$];
    int errors;

    function out_word_t compute(in_word_t w);
      out_word_t r;
      logic signed [63:0] prod;
      logic signed [63:0] num;
      logic signed [63:0] quo;
      logic signed [31:0] a;
      logic signed [31:0] b;
      a = w.operand_a;
      b = w.operand_b;
      r = '0;
      case (op_t'(w.op))
        OP_ADD: r.result_value = a + b;
        OP_SUB: r.result_value = a - b;
        OP_MUL: begin
          prod = 64'(a) * 64'(b);
          r.result_value = 32'(prod >>> FracBits);
        end
        OP_DIV: begin
          if (b == 0) begin
            r.divide_by_zero = 1'b1;
          end else begin
            num = 64'(a) <<< FracBits;
            quo = num / 64'(b);
            r.result_value = quo[31:0];
          end
        end
        OP_GT: r.compare_flag = a > b;
        OP_LT: r.compare_flag = a < b;
        OP_GE: r.compare_flag = a >= b;
        OP_LE: r.compare_flag = a <= b;
        OP_EQ: r.compare_flag = a == b;
        OP_NE: r.compare_flag = a != b;
        OP_MIN: r.result_value = (a <= b) ? a : b;
        OP_MAX: r.result_value = (a >= b) ? a : b;
        OP_INC: r.result_value = a + 32'sd1;
        OP_DEC: r.result_value = a - 32'sd1;
        OP_FROM_INT: r.result_value = a <<< FracBits;
        default: r.result_value = a >>> FracBits;
      endcase
      return r;
    endfunction

    function void note_input(in_word_t w);
      pending.push_back(compute(w));
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got.result_value !== exp_w.result_value || got.compare_flag !== exp_w.compare_flag
          || got.divide_by_zero !== exp_w.divide_by_zero) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp val %h flag %b dz %b, got val %h flag %b dz %b",
                   exp_w.result_value, exp_w.compare_flag, exp_w.divide_by_zero,
                   got.result_value, got.compare_flag, got.divide_by_zero);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_word_t in_data;
  logic out_valid;
  logic out_stall;
  out_word_t out_data;

  alu_scoreboard board;
  bit quiet_phase;
  bit hold_done;
  int idle_cycles;
  localparam int IdleLimit = 20000;

  fixed_point_alu i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one word after an optional random idle gap, holding it until accepted; valid is left high on return
  task automatic send_word(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    in_word_t w;
    w.op = op;
    w.operand_a = a;
    w.operand_b = b;
    while (!quiet_phase && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    board.note_input(w);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return $urandom_range(3) - 1;
      3: return $urandom_range(1024) - 512;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stall, one long hold-off
  initial begin
    int hold;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    repeat (200) @(negedge clk);
    out_stall <= 1'b1;
    for (hold = 0; hold < 300; hold++) @(negedge clk);
    hold_done = 1'b1;
    forever begin
      out_stall <= !quiet_phase && ($urandom_range(99) < 9);
      @(negedge clk);
    end
  end

  // Result checker and watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) board.check_result(out_data);
      if (idle_cycles > IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] edge_vals[6];
    int i;
    board = new();
    quiet_phase = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: every op on extremes, divide by zero, overflow corners
    edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h100, 32'hFFFF_FF00};
    for (i = 0; i < 16; i++) send_word(i[3:0], edge_vals[i % 6], edge_vals[(i + 1) % 6]);
    send_word(OP_DIV, 32'h1234, 32'h0);
    send_word(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(OP_DIV, 32'h8000_0000, 32'h1);
    send_word(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_word(OP_EQ, 32'h55, 32'h55);
    send_word(OP_MIN, 32'h7, 32'h7);
    send_word(OP_FROM_INT, 32'h7FFF_FFFF, 32'h0);
    send_word(OP_TO_INT, 32'hFFFF_FFFF, 32'h0);
    // Random words; a no-idle stretch in the middle
    for (i = 0; i < 1900; i++) begin
      quiet_phase = (i >= 900 && i < 1200);
      send_word(4'($urandom_range(15)), rand_operand(),
                ($urandom_range(15) == 0) ? 32'h0 : rand_operand());
    end
    in_valid <= 1'b0;
    quiet_phase = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (board.errors == 0 && hold_done) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
